// ----- rtl/core/jsu_pkg.sv -----
// Package for the JSON string unescaper: codes, the front-to-back command
// type, the queue status group and the queue sizing constants.
// Depends on nothing; every other file of the block imports it.
package jsu_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Result status codes as they appear on the status port.
  localparam logic [1:0] StByte = 2'd0;
  localparam logic [1:0] StDone = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  // Characters the front looks for.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowU      = 8'h75;

  // UTF-8 encoding constants.
  localparam logic [15:0] CpMax1 = 16'h007F;
  localparam logic [15:0] CpMax2 = 16'h07FF;
  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;
  localparam logic [5:0]  Utf8Mask  = 6'h3F;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_e;

  typedef enum logic [1:0] {
    CMD_BYTE,  // one literal byte in data[7:0]
    CMD_CP,    // a code point to be encoded as UTF-8
    CMD_DONE,  // string closed
    CMD_ERR    // error
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] data;
  } jsu_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jsu_qstat_t;

endpackage

// ----- rtl/core/jsu_front.sv -----
// Front end of the JSON string unescaper: accepts bytes, tracks the string
// mode and the hex digits of a \u escape, and issues one command per result group.
// Depends on jsu_pkg.
module jsu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_input_i,
  output logic           push_o,
  output jsu_pkg::jsu_cmd_t cmd_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [11:0] code_point_q, code_point_d;
  logic [4:0]  hex_v;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign hex_v = hex_value(in_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      hex_count_q  <= 2'd0;
      code_point_q <= 12'd0;
    end else begin
      mode_q       <= mode_d;
      hex_count_q  <= hex_count_d;
      code_point_q <= code_point_d;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    hex_count_d  = hex_count_q;
    code_point_d = code_point_q;
    push_o       = 1'b0;
    cmd_o        = '{kind: CMD_BYTE, data: 16'h0000};
    if (accept_i) begin
      if (end_of_input_i) begin
        if (mode_q != MODE_IDLE) begin
          push_o       = 1'b1;
          cmd_o.kind   = CMD_ERR;
          mode_d       = MODE_IDLE;
          hex_count_d  = 2'd0;
          code_point_d = 12'd0;
        end
      end else begin
        case (mode_q)
          MODE_IDLE: begin
            if (in_byte_i == ChQuote) begin
              mode_d = MODE_STR;
            end else begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_ERR;
            end
          end
          MODE_STR: begin
            if (in_byte_i == ChQuote) begin
              push_o       = 1'b1;
              cmd_o.kind   = CMD_DONE;
              mode_d       = MODE_IDLE;
              hex_count_d  = 2'd0;
              code_point_d = 12'd0;
            end else if (in_byte_i == ChBackslash) begin
              mode_d = MODE_ESC;
            end else begin
              push_o     = 1'b1;
              cmd_o.data = {8'h00, in_byte_i};
            end
          end
          MODE_ESC: begin
            mode_d     = MODE_STR;
            push_o     = 1'b1;
            cmd_o.data = {8'h00, in_byte_i};
            case (in_byte_i)
              ChLowB: cmd_o.data = 16'h0008;
              ChLowF: cmd_o.data = 16'h000C;
              ChLowN: cmd_o.data = 16'h000A;
              ChLowR: cmd_o.data = 16'h000D;
              ChLowT: cmd_o.data = 16'h0009;
              ChLowU: begin
                push_o       = 1'b0;
                mode_d       = MODE_HEX;
                hex_count_d  = 2'd0;
                code_point_d = 12'd0;
              end
              default: begin
              end
            endcase
          end
          default: begin
            if (!hex_v[4]) begin
              push_o       = 1'b1;
              cmd_o.kind   = CMD_ERR;
              mode_d       = MODE_IDLE;
              hex_count_d  = 2'd0;
              code_point_d = 12'd0;
            end else if (hex_count_q == 2'd3) begin
              push_o       = 1'b1;
              cmd_o.kind   = CMD_CP;
              cmd_o.data   = {code_point_q, hex_v[3:0]};
              mode_d       = MODE_STR;
              hex_count_d  = 2'd0;
              code_point_d = 12'd0;
            end else begin
              code_point_d = {code_point_q[7:0], hex_v[3:0]};
              hex_count_d  = hex_count_q + 2'd1;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/jsu_queue.sv -----
// Short command queue between the front and back of the unescaper.
// Depends on jsu_pkg for the command type, status group and depth.
module jsu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jsu_pkg::jsu_cmd_t    push_cmd_i,
  input  logic                 pop_i,
  output jsu_pkg::jsu_cmd_t    head_o,
  output jsu_pkg::jsu_qstat_t  stat_o
);
  import jsu_pkg::*;

  jsu_cmd_t             slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign stat_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QueueCntW'(1);
        2'b01:   count_q <= count_q - QueueCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/jsu_back.sv -----
// Back end of the unescaper: takes commands from the queue and serializes
// them into result items, encoding code points as one to three UTF-8 bytes.
// Depends on jsu_pkg.
module jsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jsu_pkg::jsu_cmd_t   head_i,
  input  jsu_pkg::jsu_qstat_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          status_o,
  output logic                last_o
);
  import jsu_pkg::*;

  jsu_cmd_t   cur_q;
  logic       cur_valid_q;
  logic [1:0] step_q;
  logic [1:0] n_out;
  logic       out_fire;

  // Number of result items the current command produces, minus one.
  always_comb begin
    n_out = 2'd0;
    if (cur_q.kind == CMD_CP) begin
      if (cur_q.data <= CpMax1) begin
        n_out = 2'd0;
      end else if (cur_q.data <= CpMax2) begin
        n_out = 2'd1;
      end else begin
        n_out = 2'd2;
      end
    end
  end

  always_comb begin
    out_byte_o = 8'h00;
    status_o   = StByte;
    case (cur_q.kind)
      CMD_BYTE: out_byte_o = cur_q.data[7:0];
      CMD_DONE: status_o = StDone;
      CMD_ERR:  status_o = StErr;
      default: begin
        if (n_out == 2'd0) begin
          out_byte_o = cur_q.data[7:0];
        end else if (n_out == 2'd1) begin
          out_byte_o = (step_q == 2'd0) ? (Utf8Lead2 | {3'b000, cur_q.data[10:6]})
                                        : (Utf8Cont | {2'b00, cur_q.data[5:0] & Utf8Mask});
        end else begin
          case (step_q)
            2'd0:    out_byte_o = Utf8Lead3 | {4'h0, cur_q.data[15:12]};
            2'd1:    out_byte_o = Utf8Cont | {2'b00, cur_q.data[11:6] & Utf8Mask};
            default: out_byte_o = Utf8Cont | {2'b00, cur_q.data[5:0] & Utf8Mask};
          endcase
        end
      end
    endcase
  end

  assign last_o      = (step_q == n_out);
  assign out_valid_o = cur_valid_q;
  assign out_fire    = cur_valid_q && !out_stall_i;
  assign pop_o       = !qstat_i.empty && (!cur_valid_q || (out_fire && last_o));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      step_q      <= 2'd0;
    end else if (out_fire) begin
      if (last_o) begin
        cur_valid_q <= 1'b0;
        step_q      <= 2'd0;
      end else begin
        step_q <= step_q + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/json_string_unescape.sv -----
// Top level of the JSON string unescaper: front end, command queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Usage: bytes of a double-quoted JSON string literal enter on the input
// channel (in_valid_i, in_stall_o, in_byte_i, end_of_input_i), one item per
// cycle while in_stall_o is low. The decoded result items leave on the
// output channel (out_valid_o, out_stall_i, out_byte_o, status_o, last_o).
// Status 0 carries a content byte, 1 marks the closing quote, 2 an error;
// close and error items carry byte 0 and last set. Each input item causes
// zero to three result items, the last of them flagged by last_o.
// Path of an accepted input item: the front classifies the byte into a
// command in the cycle it is accepted, the queue registers the command, and
// the back register loads it from the queue head and presents it.
// Throughput is one input item per cycle while the queue has room; the back
// end emits one result item per cycle unless the receiver stalls, so a \u
// escape that encodes to two or three UTF-8 bytes holds it for each byte.
// The four-entry queue absorbs such bursts; in_stall_o rises only when full.
// When the receiver stalls, the current result item holds on the ports and
// the queue keeps filling until full. Reset empties the queue and the output
// register and returns the front end to idle, waiting for an opening quote.
module json_string_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic       in_accept;
  logic       q_push;
  logic       q_pop;
  jsu_cmd_t   push_cmd;
  jsu_cmd_t   head_cmd;
  jsu_qstat_t qstat;

  // Stall only on a full queue; an input item may then not push anything, but
  // holding it off keeps the decision independent of the byte's class.
  assign in_stall_o = qstat.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (q_push),
    .cmd_o          (push_cmd)
  );

  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .stat_o     (qstat)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // A command is never pushed into a full queue, or it would be lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !qstat.full)
    else $error("command pushed into a full queue");

  // Close and error results always end their group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StByte) |-> last_o)
    else $error("close or error result without last");

  // Finishing a group with nothing queued leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o && qstat.empty) |=> !out_valid_o)
    else $error("result appeared without a queued command");

  // The output holds only known status codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StByte || status_o == StDone || status_o == StErr))
    else $error("reserved status code on output");

endmodule

// ----- tb/json_string_unescape_tb.sv -----
// Self-checking testbench for json_string_unescape: directed and random JSON string
// literals on the input channel, decoded bytes checked against an in-bench decoder.
// Depends on jsu_pkg and the json_string_unescape RTL.
`timescale 1ns / 100ps

module json_string_unescape_tb;
  import jsu_pkg::*;

  // Characters and decoded control bytes that the package does not name.
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChCapA  = 8'h41;
  localparam logic [7:0] ChCapF  = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowG  = 8'h67;
  localparam logic [7:0] CtlBsp  = 8'h08;
  localparam logic [7:0] CtlTab  = 8'h09;
  localparam logic [7:0] CtlLf   = 8'h0A;
  localparam logic [7:0] CtlFf   = 8'h0C;
  localparam logic [7:0] CtlCr   = 8'h0D;

  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 145;
  localparam int LongHold     = 80;
  localparam int TailCycles   = 8;
  localparam int MaxReported  = 10;

  // How the expected results of a directed row are obtained.
  typedef enum logic [1:0] {
    EXP_PRED,  // from the decoder below
    EXP_NONE,  // typed in: the row causes no result
    EXP_ONE    // typed in: the row causes exactly one result
  } exp_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } src_item_t;

  typedef struct packed {
    exp_kind_e  kind;
    logic [7:0] b;
    logic       eoi;
    logic [7:0] data_byte;
    logic [1:0] status;
  } dir_row_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i      = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       last_o;

  json_string_unescape u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Decoder state, mirroring what the block must hold between items.
  mode_e       dec_mode = MODE_IDLE;
  logic [1:0]  hex_cnt  = 2'd0;
  logic [15:0] cp_acc   = 16'h0000;

  // Results of the most recent decode step, in output order.
  result_t     step_res [3];

  // Decoded results still owed by the block, oldest first.
  result_t     decoded_q [$];
  // Source bytes of the random strings, waiting to be offered.
  src_item_t   src_q [$];

  int          mismatches  = 0;
  int          items_done  = 0;
  int          cycle_cnt   = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  logic        hold_req    = 1'b0;
  logic        hold_taken  = 1'b0;
  int          hold_cnt    = 0;

  dir_row_t    dir_tbl [25];

  // ---------------------------------------------------------------------------
  // Decoder. One call per accepted item; fills step_res and returns how many
  // results the item causes (zero to three).
  // ---------------------------------------------------------------------------
  function automatic int hex_val(logic [7:0] c);
    if (c >= Ch0 && c <= Ch9) return int'(c - Ch0);
    if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
    if (c >= ChCapA && c <= ChCapF) return int'(c - ChCapA) + 10;
    return -1;
  endfunction

  function automatic void go_idle();
    dec_mode = MODE_IDLE;
    hex_cnt  = 2'd0;
    cp_acc   = 16'h0000;
  endfunction

  // A single result, which is always the last one of its item.
  function automatic int single(logic [7:0] data_byte, logic [1:0] status);
    step_res[0] = '{data_byte, status, 1'b1};
    return 1;
  endfunction

  // UTF-8 encoding of one code point; surrogates are encoded like any other.
  function automatic int encode_utf8(logic [15:0] cp);
    if (cp <= 16'h007F) return single(cp[7:0], StByte);
    if (cp <= 16'h07FF) begin
      step_res[0] = '{{3'b110, cp[10:6]}, StByte, 1'b0};
      step_res[1] = '{{2'b10, cp[5:0]}, StByte, 1'b1};
      return 2;
    end
    step_res[0] = '{{4'b1110, cp[15:12]}, StByte, 1'b0};
    step_res[1] = '{{2'b10, cp[11:6]}, StByte, 1'b0};
    step_res[2] = '{{2'b10, cp[5:0]}, StByte, 1'b1};
    return 3;
  endfunction

  function automatic int unescape_step(logic [7:0] b, logic eoi);
    int          hv;
    logic [15:0] cp;
    // The end of the source only matters while a string is open.
    if (eoi) begin
      if (dec_mode == MODE_IDLE) return 0;
      go_idle();
      return single(8'h00, StErr);
    end
    case (dec_mode)
      MODE_IDLE: begin
        if (b == ChQuote) begin
          dec_mode = MODE_STR;
          return 0;
        end
        return single(8'h00, StErr);
      end
      MODE_STR: begin
        if (b == ChQuote) begin
          go_idle();
          return single(8'h00, StDone);
        end
        if (b == ChBackslash) begin
          dec_mode = MODE_ESC;
          return 0;
        end
        return single(b, StByte);
      end
      MODE_ESC: begin
        dec_mode = MODE_STR;
        case (b)
          ChLowB: return single(CtlBsp, StByte);
          ChLowF: return single(CtlFf, StByte);
          ChLowN: return single(CtlLf, StByte);
          ChLowR: return single(CtlCr, StByte);
          ChLowT: return single(CtlTab, StByte);
          ChLowU: begin
            dec_mode = MODE_HEX;
            hex_cnt  = 2'd0;
            cp_acc   = 16'h0000;
            return 0;
          end
          // Quote, backslash, slash and every other byte stand for themselves.
          default: return single(b, StByte);
        endcase
      end
      default: begin
        hv = hex_val(b);
        if (hv < 0) begin
          go_idle();
          return single(8'h00, StErr);
        end
        cp_acc = {cp_acc[11:0], hv[3:0]};
        if (hex_cnt == 2'd3) begin
          cp       = cp_acc;
          dec_mode = MODE_STR;
          hex_cnt  = 2'd0;
          cp_acc   = 16'h0000;
          return encode_utf8(cp);
        end
        hex_cnt = hex_cnt + 2'd1;
        return 0;
      end
    endcase
  endfunction

  // Appends one result to the list of results still owed by the block.
  function automatic void book_result(result_t r);
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Offers one item at the falling edge, holds it until it is taken
  // at a rising edge, then books the results that the item must cause.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eoi, input exp_kind_e kind,
                           input logic [7:0] data_byte, input logic [1:0] status);
    int n;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i     <= 1'b0;
      in_byte_i      <= 8'($urandom_range(255));
      end_of_input_i <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= b;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
    // The decoder runs on every accepted item, typed rows included, so that
    // its state follows the block.
    n = unescape_step(b, eoi);
    if (kind == EXP_PRED) begin
      for (int i = 0; i < n; i++) book_result(step_res[i]);
    end else if (kind == EXP_ONE) begin
      book_result('{data_byte, status, 1'b1});
    end
    items_done++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random string builder. Most strings are well formed with random content;
  // some end early, run into a bad hex digit, are left open, or are just
  // stray bytes offered while no string is open.
  // ---------------------------------------------------------------------------
  function automatic void push_src(logic [7:0] b, logic eoi = 1'b0);
    src_item_t it;
    it = '{b, eoi};
    src_q.insert(src_q.size(), it);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return Ch0 + 8'(nib);
    return ($urandom_range(1) ? ChLowA : ChCapA) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] esc_letter(int idx);
    case (idx)
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChLowB;
      4: return ChLowF;
      5: return ChLowN;
      6: return ChLowR;
      default: return ChLowT;
    endcase
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom_range(16'hFFFF, 16'h0800));
      default: begin
        // Boundaries between the one, two and three byte encodings.
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic void push_hex_escape(logic [15:0] cp);
    push_src(ChBackslash);
    push_src(ChLowU);
    for (int i = 3; i >= 0; i--) push_src(hex_char(cp[4*i +: 4]));
  endfunction

  function automatic void build_string();
    logic [7:0]  b;
    int          ntok;
    int          good;
    int          ending;
    if ($urandom_range(99) < 8) begin
      // Noise while idle: either a stray byte or a bare end of source.
      push_src(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    push_src(ChQuote);
    ntok = $urandom_range(6);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(255)); while (b == ChQuote || b == ChBackslash);
          push_src(b);
        end
        4, 5: begin
          push_src(ChBackslash);
          push_src(esc_letter($urandom_range(7)));
        end
        6: begin
          // Any escaped byte; a u here turns the next bytes into hex digits.
          push_src(ChBackslash);
          push_src(8'($urandom_range(255)));
        end
        default: push_hex_escape(pick_code_point());
      endcase
    end
    ending = $urandom_range(99);
    if (ending < 80) begin
      push_src(ChQuote);
    end else if (ending < 88) begin
      push_src(8'($urandom_range(255)), 1'b1);
    end else if (ending < 96) begin
      push_src(ChBackslash);
      push_src(ChLowU);
      good = $urandom_range(3);
      for (int i = 0; i < good; i++) push_src(hex_char(4'($urandom_range(15))));
      do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
      push_src(b);
    end
    // Otherwise the string stays open and the next one's quote closes it.
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver. Stalls at random at the falling edge. Once, on request, it holds
  // off for a long stretch so that the internal queue fills and the block
  // stalls its input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cnt   = LongHold;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rst_ni && ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Every result taken at a rising edge is compared with the
  // oldest booked result, field by field.
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string why, input result_t want);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t: %s: expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
               $realtime, why, want.data_byte, want.status, want.last,
               out_byte_o, status_o, last_o);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        log_mismatch("result with nothing outstanding", '0);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data_byte || status_o !== want.status || last_o !== want.last)
          log_mismatch("wrong result", want);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, three random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    src_item_t s;
    int        target;

    // Directed rows. Results are typed in where they are obvious: nothing at
    // all for an end of source while idle, errors, the close, and raw bytes
    // at the ends of the range. The escapes go through the decoder.
    dir_tbl = '{
      '{EXP_NONE, 8'h5A,       1'b1, 8'h00, StByte},  // end of source, no string open
      '{EXP_ONE,  8'h00,       1'b0, 8'h00, StErr},   // idle, not a quote
      '{EXP_ONE,  8'hFF,       1'b0, 8'h00, StErr},   // idle, not a quote
      '{EXP_NONE, ChQuote,     1'b0, 8'h00, StByte},  // opening quote
      '{EXP_ONE,  8'hFF,       1'b0, 8'hFF, StByte},  // raw byte, top of range
      '{EXP_ONE,  8'h00,       1'b0, 8'h00, StByte},  // raw byte, bottom of range
      '{EXP_PRED, ChBackslash, 1'b0, 8'h00, StByte},
      '{EXP_PRED, ChLowB,      1'b0, 8'h00, StByte},
      '{EXP_PRED, ChBackslash, 1'b0, 8'h00, StByte},
      '{EXP_PRED, ChLowF,      1'b0, 8'h00, StByte},
      '{EXP_PRED, ChBackslash, 1'b0, 8'h00, StByte},  // largest code point, mixed case
      '{EXP_PRED, ChLowU,      1'b0, 8'h00, StByte},
      '{EXP_PRED, ChCapF,      1'b0, 8'h00, StByte},
      '{EXP_PRED, ChLowF,      1'b0, 8'h00, StByte},
      '{EXP_PRED, ChLowF,      1'b0, 8'h00, StByte},
      '{EXP_PRED, ChLowF,      1'b0, 8'h00, StByte},
      '{EXP_ONE,  ChQuote,     1'b0, 8'h00, StDone},  // closing quote
      '{EXP_PRED, ChQuote,     1'b0, 8'h00, StByte},
      '{EXP_PRED, ChBackslash, 1'b0, 8'h00, StByte},
      '{EXP_PRED, ChLowU,      1'b0, 8'h00, StByte},
      '{EXP_PRED, Ch0,         1'b0, 8'h00, StByte},
      '{EXP_ONE,  ChLowG,      1'b0, 8'h00, StErr},   // bad hex digit
      '{EXP_PRED, ChQuote,     1'b0, 8'h00, StByte},
      '{EXP_PRED, ChBackslash, 1'b0, 8'h00, StByte},
      '{EXP_ONE,  8'h22,       1'b1, 8'h00, StErr}    // source ends inside an escape
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // First idling pattern: the sender rarely idles, the receiver often stalls.
    snd_idle_pct = 10;
    rcv_idle_pct = 61;
    foreach (dir_tbl[i])
      send_item(dir_tbl[i].b, dir_tbl[i].eoi, dir_tbl[i].kind,
                dir_tbl[i].data_byte, dir_tbl[i].status);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 10;
          rcv_idle_pct = 61;
          // The long hold-off starts here, with the sender busy.
          hold_req = 1'b1;
        end
        1: begin
          snd_idle_pct = 61;
          rcv_idle_pct = 10;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      target = items_done + PhaseItems;
      while (items_done < target) begin
        build_string();
        while (src_q.size() != 0) begin
          s = src_q.pop_front();
          send_item(s.b, s.eoi, EXP_PRED, 8'h00, StByte);
        end
      end
    end

    in_valid_i <= 1'b0;
    // Wait for every booked result, then a few more cycles so that a stray
    // extra result would still be seen.
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
